// ===== design/emd_pkg.sv =====
// ----------------------------------------------------------------------------
// emd_pkg
// Types and codes shared by the expiring message deque core: command and
// result payloads, stored entry layout, operation and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package emd_pkg;

    // operation requested by one command
    typedef enum logic [2:0] {
        MODE_APPEND     = 3'd0,
        MODE_PREPEND    = 3'd1,
        MODE_POP        = 3'd2,
        MODE_DROP       = 3'd3,
        MODE_DISCONNECT = 3'd4,
        MODE_ERROR      = 3'd5,
        MODE_TIMEOUT    = 3'd6
    } mode_t;

    // status reported with each result
    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_DISCONNECTED = 3'd1,
        STAT_TIMED_OUT    = 3'd2,
        STAT_ERROR        = 3'd3,
        STAT_EMPTY        = 3'd4,
        STAT_FULL         = 3'd5
    } status_t;

    // controller state
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_PURGE = 1'b1
    } state_t;

    // one command transfer
    typedef struct packed {
        mode_t       mode;
        logic [31:0] msg_tag;
        logic [15:0] owner_id;
        logic [31:0] expiry_time;
        logic        stateful_flag;
        logic [31:0] now_time;
        logic [15:0] error_code;
    } cmd_t;

    // one result transfer
    typedef struct packed {
        status_t     status;
        logic [31:0] out_tag;
        logic [15:0] out_owner;
        logic [31:0] out_expiry;
        logic        out_stateful;
        logic [15:0] out_error;
        logic        last;
    } rsp_t;

    // one stored queue entry
    typedef struct packed {
        logic [31:0] tag;
        logic [15:0] owner;
        logic [31:0] expiry;
        logic        stateful;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/expiring_message_deque_core.sv =====
// ----------------------------------------------------------------------------
// expiring_message_deque_core
// Bounded deque of pending message entries held in one synchronous memory.
// Push, pop and drop run one per cycle while not busy; purges walk the queue and compact
// the survivors in place.
// ----------------------------------------------------------------------------
//  channel   ports                  direction  transfer
//  command   start, busy, cmd       in         start && !busy at clk rise
//  result    rsp_valid, rsp         out        rsp_valid for one cycle
//
//  push, pop and drop: one command per cycle while not busy; the result passes
//  through stage one (the echo or the memory read), then the output register.
//  purges: busy while the walk runs; the walk
//  reads one entry a cycle and writes survivors back behind the read pointer.
//  a removed entry is held in a pending register so that last can be marked on the final one.
//  reset clears head, count and control; the entry memory is not cleared.
//  the receiver cannot stall; results are never held off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module expiring_message_deque_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire emd_pkg::cmd_t cmd,
    output logic               rsp_valid,
    output emd_pkg::rsp_t      rsp
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // entry memory
    emd_pkg::entry_t mem [QUEUE_DEPTH];
    emd_pkg::entry_t rd_data_reg;

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    emd_pkg::entry_t wr_data;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;

    // control state
    emd_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            s1_valid_reg, s1_valid_next;
    logic            s1_from_mem_reg, s1_from_mem_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic            chk_valid_reg, chk_valid_next;
    logic [CW-1:0]   wr_idx_reg, wr_idx_next;
    logic            pend_valid_reg, pend_valid_next;

    // payload
    emd_pkg::rsp_t   s1_rsp_reg, s1_rsp_next;
    emd_pkg::rsp_t   rsp_reg, rsp_next;
    emd_pkg::rsp_t   pend_reg, pend_next;
    emd_pkg::mode_t  pmode_reg, pmode_next;
    logic [31:0]     pnow_reg, pnow_next;
    logic [15:0]     perr_reg, perr_next;

    // purge walk helpers
    logic            remove;
    emd_pkg::rsp_t   item;
    emd_pkg::status_t purge_status;

    // slot of queue position off behind the head, wrapped at the depth
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, head} + (IW+1)'(off);
        if (sum >= (IW+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (IW+1)'(QUEUE_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= emd_pkg::ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            s1_valid_reg   <= s1_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_from_mem_reg <= s1_from_mem_next;
        s1_rsp_reg      <= s1_rsp_next;
        rsp_reg         <= rsp_next;
        pend_reg        <= pend_next;
        pmode_reg       <= pmode_next;
        pnow_reg        <= pnow_next;
        perr_reg        <= perr_next;
    end

    // purge decision on the entry read last cycle
    always_comb
    begin
        case (pmode_reg)
            emd_pkg::MODE_DISCONNECT:
            begin
                remove       = rd_data_reg.stateful;
                purge_status = emd_pkg::STAT_DISCONNECTED;
            end
            emd_pkg::MODE_ERROR:
            begin
                remove       = 1'b1;
                purge_status = emd_pkg::STAT_ERROR;
            end
            default:
            begin
                remove       = (rd_data_reg.expiry <= pnow_reg);
                purge_status = emd_pkg::STAT_TIMED_OUT;
            end
        endcase
        item.status       = purge_status;
        item.out_tag      = rd_data_reg.tag;
        item.out_owner    = rd_data_reg.owner;
        item.out_expiry   = rd_data_reg.expiry;
        item.out_stateful = rd_data_reg.stateful;
        item.out_error    = (pmode_reg == emd_pkg::MODE_ERROR) ? perr_reg : 16'd0;
        item.last         = 1'b0;
    end

    // next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        s1_valid_next    = 1'b0;
        s1_from_mem_next = 1'b0;
        s1_rsp_next      = s1_rsp_reg;
        rd_idx_next      = rd_idx_reg;
        chk_valid_next   = 1'b0;
        wr_idx_next      = wr_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        pmode_next       = pmode_reg;
        pnow_next        = pnow_reg;
        perr_next        = perr_reg;
        wr_en            = 1'b0;
        wr_addr          = head_reg;
        wr_data          = rd_data_reg;
        rd_en            = 1'b0;
        rd_addr          = head_reg;

        // output stage: finish the item held in stage one
        rsp_valid_next = s1_valid_reg;
        if (s1_from_mem_reg)
        begin
            rsp_next.status       = emd_pkg::STAT_OK;
            rsp_next.out_tag      = rd_data_reg.tag;
            rsp_next.out_owner    = rd_data_reg.owner;
            rsp_next.out_expiry   = rd_data_reg.expiry;
            rsp_next.out_stateful = rd_data_reg.stateful;
            rsp_next.out_error    = 16'd0;
            rsp_next.last         = 1'b1;
        end
        else
        begin
            rsp_next = s1_rsp_reg;
        end

        case (state_reg)
            emd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // echo of the command for push results
                    s1_rsp_next.status       = emd_pkg::STAT_OK;
                    s1_rsp_next.out_tag      = cmd.msg_tag;
                    s1_rsp_next.out_owner    = cmd.owner_id;
                    s1_rsp_next.out_expiry   = cmd.expiry_time;
                    s1_rsp_next.out_stateful = cmd.stateful_flag;
                    s1_rsp_next.out_error    = 16'd0;
                    s1_rsp_next.last         = 1'b1;
                    wr_data.tag              = cmd.msg_tag;
                    wr_data.owner            = cmd.owner_id;
                    wr_data.expiry           = cmd.expiry_time;
                    wr_data.stateful         = cmd.stateful_flag;
                    case (cmd.mode)
                        emd_pkg::MODE_APPEND,
                        emd_pkg::MODE_PREPEND:
                        begin
                            s1_valid_next = 1'b1;
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                s1_rsp_next.status = emd_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (cmd.mode == emd_pkg::MODE_APPEND)
                                begin
                                    wr_addr = slot_of(head_reg, count_reg);
                                end
                                else
                                begin
                                    head_next = (head_reg == '0) ?
                                                IW'(QUEUE_DEPTH - 1) :
                                                head_reg - IW'(1);
                                    wr_addr   = head_next;
                                end
                            end
                        end
                        emd_pkg::MODE_POP,
                        emd_pkg::MODE_DROP:
                        begin
                            s1_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                s1_rsp_next              = '0;
                                s1_rsp_next.status       = emd_pkg::STAT_EMPTY;
                                s1_rsp_next.last         = 1'b1;
                            end
                            else
                            begin
                                rd_en            = 1'b1;
                                rd_addr          = head_reg;
                                s1_from_mem_next = 1'b1;
                                head_next        = slot_of(head_reg, CW'(1));
                                count_next       = count_reg - CW'(1);
                            end
                        end
                        emd_pkg::MODE_DISCONNECT,
                        emd_pkg::MODE_ERROR,
                        emd_pkg::MODE_TIMEOUT:
                        begin
                            state_next      = emd_pkg::ST_PURGE;
                            rd_idx_next     = '0;
                            wr_idx_next     = '0;
                            pend_valid_next = 1'b0;
                            pmode_next      = cmd.mode;
                            pnow_next       = cmd.now_time;
                            perr_next       = cmd.error_code;
                        end
                        default:
                        begin
                            // unused mode: no result, no change
                        end
                    endcase
                end
            end

            emd_pkg::ST_PURGE:
            begin
                // check the entry read last cycle
                if (chk_valid_reg)
                begin
                    if (remove)
                    begin
                        if (pend_valid_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = pend_reg;
                        end
                        pend_next       = item;
                        pend_valid_next = 1'b1;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = slot_of(head_reg, wr_idx_reg);
                        wr_data     = rd_data_reg;
                        wr_idx_next = wr_idx_reg + CW'(1);
                    end
                end

                // read the next entry of the walk
                if (rd_idx_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = slot_of(head_reg, rd_idx_reg);
                    rd_idx_next    = rd_idx_reg + CW'(1);
                    chk_valid_next = 1'b1;
                end

                // walk finished: flush the held result as the last one
                if (!chk_valid_reg && (rd_idx_reg == count_reg))
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = pend_reg;
                        rsp_next.last  = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    count_next      = wr_idx_reg;
                    state_next      = emd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = emd_pkg::ST_IDLE;
            end
        endcase
    end

    // ports
    assign busy      = (state_reg != emd_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
